// ----- hdl/fpsc_pkg.sv -----
// package: types and constants (Q16.16 word and fraction widths) for the frustum cull block
`timescale 1ns / 1ps
package fpsc_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;
    localparam int PLANE_COUNT    = 6;

    typedef enum logic [1:0] {
        FUNC_LOAD_PROJ = 2'd0,
        FUNC_LOAD_MV   = 2'd1,
        FUNC_EXTRACT   = 2'd2,
        FUNC_TEST      = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        radius;
        logic [30:0]        visible_ratio;
    } t_in_item;

    typedef struct packed {
        logic visible;
        logic planes_valid;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MM_MUL,
        ST_MM_ACC,
        ST_PL_FORM,
        ST_PL_SQ,
        ST_PL_SQRT,
        ST_PL_DIV,
        ST_PL_DSTEP,
        ST_T_ADJ,
        ST_T_MUL,
        ST_T_ACC,
        ST_T_CMP,
        ST_OUT
    } t_state;

endpackage

// ----- hdl/fpsc_mulq.sv -----
// shared multiplier: rounded, saturated fixed-point product, one register stage
`timescale 1ns / 1ps
module fpsc_mulq #(
    parameter int W = fpsc_pkg::WORD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [W-1:0] o_p,
    output logic [2*W-1:0]      o_sq
);
    import fpsc_pkg::*;

    logic [W-1:0]   w_ma;
    logic [W-1:0]   w_mb;
    logic [2*W-1:0] w_prod;
    logic [2*W-1:0] w_rnd;
    logic [2*W-1:0] w_q;
    logic [2*W-1:0] w_lim;
    logic           w_neg;
    logic signed [W-1:0] r_p;
    logic [2*W-1:0] r_sq;

    // magnitudes and full product
    always_comb begin
        w_ma   = i_a[W-1] ? (~i_a + 1'b1) : i_a;
        w_mb   = i_b[W-1] ? (~i_b + 1'b1) : i_b;
        w_neg  = i_a[W-1] ^ i_b[W-1];
        w_prod = w_ma * w_mb;
        w_rnd  = w_prod + (2*W)'(1 << (FRAC_BITS - 1));
        w_q    = w_rnd >> FRAC_BITS;
        w_lim  = w_neg ? ((2*W)'(1) << (W-1)) : (((2*W)'(1) << (W-1)) - 1'b1);
        if (w_rnd < w_prod || w_q > w_lim) begin
            w_q = w_lim;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_p  <= w_neg ? W'(~w_q + 1'b1) : W'(w_q);
        r_sq <= w_prod;
    end

    assign o_p  = r_p;
    assign o_sq = r_sq;
endmodule

// ----- hdl/fpsc_divsqrt.sv -----
// bit-serial unit: integer square root or rounded fixed-point quotient
`timescale 1ns / 1ps
module fpsc_divsqrt #(
    parameter int W = fpsc_pkg::WORD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_is_sqrt,
    input  logic [2*W+1:0]      i_rad,
    input  logic signed [W-1:0] i_num,
    input  logic [W+2:0]        i_den,
    output logic                o_done,
    output logic [W+2:0]        o_root,
    output logic signed [W-1:0] o_quot
);
    import fpsc_pkg::*;

    localparam int RB = W + 3;            // root bits
    localparam int QB = W + FRAC_BITS + 1; // quotient bits
    localparam int NB = W + FRAC_BITS;
    localparam int CW = $clog2(2*RB + QB + 2);

    logic          r_busy;
    logic          r_sqrt;
    logic [CW-1:0] r_cnt;
    logic [2*RB-1:0] r_rem;
    logic [2*RB-1:0] r_src;
    logic [RB-1:0] r_root;
    logic [QB-1:0] r_q;
    logic [NB-1:0] r_n;
    logic          r_neg;
    logic [RB-1:0] r_den;
    logic          r_done;

    logic [2*RB-1:0] w_trial;
    logic [2*RB-1:0] w_rs;
    logic [RB+1:0]   w_dr;
    logic [RB+1:0]   w_dsub;
    logic [RB+1:0]   w_rem_nx;
    logic            w_rflag;
    logic [QB:0]     w_qr;
    logic [QB:0]     w_lim;

    // one root bit or one quotient bit per cycle
    always_comb begin
        w_rs     = {r_rem[2*RB-3:0], r_src[2*RB-1 -: 2]};
        w_trial  = {{(RB-2){1'b0}}, r_root, 2'b01};
        w_dr     = {r_rem[RB:0], r_n[NB-1]};
        w_dsub   = w_dr - {2'b00, r_den};
        w_rem_nx = !w_dsub[RB+1] ? w_dsub : w_dr;
        // rounding flag: 2*rem >= den
        w_rflag  = ({w_rem_nx[RB:0], 1'b0} >= {2'b00, r_den});
        w_qr     = {1'b0, r_q} + {1'b0, {(QB-1){1'b0}}, r_rem[0]};
        w_lim    = r_neg ? ((QB+1)'(1) << (W-1)) : (((QB+1)'(1) << (W-1)) - 1'b1);
        if (w_qr > w_lim) w_qr = w_lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_is_sqrt;
                r_rem  <= '0;
                r_root <= '0;
                r_q    <= '0;
                r_src  <= (2*RB)'(i_rad);
                r_neg  <= i_num[W-1];
                r_n    <= {(i_num[W-1] ? W'(~i_num + 1'b1) : i_num), {FRAC_BITS{1'b0}}};
                r_den  <= i_den;
                r_cnt  <= i_is_sqrt ? CW'(RB) : CW'(NB + 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_sqrt) begin
                    r_src <= r_src << 2;
                    if (w_rs >= w_trial) begin
                        r_rem  <= w_rs - w_trial;
                        r_root <= {r_root[RB-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rs;
                        r_root <= {r_root[RB-2:0], 1'b0};
                    end
                    if (r_cnt == CW'(1)) begin
                        r_busy <= 1'b0;
                    end
                end else if (r_cnt == CW'(1)) begin
                    // round: rounding flag sits in rem[0]
                    r_q    <= w_qr[QB-1:0];
                    r_busy <= 1'b0;
                end else begin
                    r_n <= r_n << 1;
                    r_q <= {r_q[QB-2:0], !w_dsub[RB+1]};
                    // last quotient bit keeps only the rounding flag
                    if (r_cnt == CW'(2)) begin
                        r_rem <= (2*RB)'(w_rflag);
                    end else begin
                        r_rem <= (2*RB)'(w_rem_nx);
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
    assign o_quot = r_neg ? W'(~r_q + 1'b1) : W'(r_q);
endmodule

// ----- hdl/frustum_plane_sphere_cull_top.sv -----
// top level: item handshake, matrix and plane stores, sequencer over shared units
// load, test and extract items each run their own state sequence up to the result; in extract,
// each plane with a zero-length normal skips its four divides
// throughput: one item at a time, the next item is taken the cycle after the result registers
// extract time is set by the bit-serial divide/root unit, test time by the shared multiplier
// reset: synchronous active low; planes clear to zero, planes_valid clears, matrices undefined
`timescale 1ns / 1ps
module frustum_plane_sphere_cull_top #(
    parameter int WORD_WIDTH = fpsc_pkg::WORD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  fpsc_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output fpsc_pkg::t_out_item o_data
);
    import fpsc_pkg::*;

    localparam int W = WORD_WIDTH;
    localparam logic signed [W+3:0] WMAX = (W+4)'((64'(1) << (W-1)) - 1);
    localparam logic signed [W+3:0] WMIN = -WMAX - 1;

    t_state r_st, n_st;
    t_in_item r_in;
    logic signed [W-1:0] r_proj [16];
    logic signed [W-1:0] r_mv   [16];
    logic signed [W-1:0] r_clip [16];
    logic signed [W-1:0] r_pl   [24];
    logic        r_pvalid;
    logic        r_vis;
    logic [3:0]  r_e;       // clip element
    logic [1:0]  r_k;       // inner index
    logic [2:0]  r_p;
    logic signed [W+3:0] r_acc;
    logic [2*W+1:0] r_sq;
    logic [W+2:0] r_len;
    logic signed [W-1:0] r_adj;
    logic        r_ph;      // multiply or divide/root phase
    logic        r_ovld;

    logic signed [W-1:0] w_ma, w_mb, w_mp;
    logic [2*W-1:0] w_msq;
    logic        w_start, w_sqrt, w_done;
    logic [W+2:0] w_root;
    logic signed [W-1:0] w_quot;
    logic signed [W-1:0] w_cx [3];
    logic signed [W+1:0] w_form;

    function automatic logic signed [W-1:0] f_sat(input logic signed [W+3:0] v);
        if (v > WMAX) return WMAX[W-1:0];
        if (v < WMIN) return WMIN[W-1:0];
        return v[W-1:0];
    endfunction

    // saturate a 32-bit input value to the word
    function automatic logic signed [W-1:0] f_in(input logic signed [31:0] v);
        if (64'(v) > 64'(WMAX)) return WMAX[W-1:0];
        if (64'(v) < 64'(WMIN)) return WMIN[W-1:0];
        return W'(v);
    endfunction

    assign w_cx[0] = f_in(r_in.center_x);
    assign w_cx[1] = f_in(r_in.center_y);
    assign w_cx[2] = f_in(r_in.center_z);

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_st)
            ST_MM_MUL: begin
                w_ma = r_mv[{r_e[3:2], r_k}];
                w_mb = r_proj[{r_k, r_e[1:0]}];
            end
            ST_PL_SQ: begin
                w_ma = r_pl[{r_p, 2'b00} + 5'(r_k)];
                w_mb = w_ma;
            end
            ST_T_ADJ: begin
                w_ma = f_in($signed({1'b0, r_in.radius}));
                w_mb = f_in($signed({1'b0, r_in.visible_ratio}));
            end
            ST_T_MUL: begin
                w_ma = r_pl[{r_p, 2'b00} + 5'(r_k)];
                w_mb = w_cx[r_k];
            end
            default: ;
        endcase
    end

    fpsc_mulq #(.W(W)) u_mul (
        .i_clk (i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp), .o_sq(w_msq)
    );

    assign w_sqrt  = (r_st == ST_PL_SQRT) && !r_ph;
    assign w_start = ((r_st == ST_PL_SQRT) || (r_st == ST_PL_DIV)) && !r_ph;

    fpsc_divsqrt #(.W(W)) u_ds (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_is_sqrt(w_sqrt),
        .i_rad(r_sq), .i_num(r_pl[{r_p, 2'b00} + 5'(r_k)]), .i_den(r_len),
        .o_done(w_done), .o_root(w_root), .o_quot(w_quot)
    );

    // plane formation: column 3 plus or minus column of axis
    always_comb begin
        if (r_p[0]) w_form = {{2{r_clip[{r_k, 2'd3}][W-1]}}, r_clip[{r_k, 2'd3}]}
                          - {{2{r_clip[{r_k, r_p[2:1]}][W-1]}}, r_clip[{r_k, r_p[2:1]}]};
        else        w_form = {{2{r_clip[{r_k, 2'd3}][W-1]}}, r_clip[{r_k, 2'd3}]}
                          + {{2{r_clip[{r_k, r_p[2:1]}][W-1]}}, r_clip[{r_k, r_p[2:1]}]};
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_valid) begin
                unique case (t_func'(i_data.func))
                    FUNC_EXTRACT: n_st = ST_MM_MUL;
                    FUNC_TEST:    n_st = ST_T_ADJ;
                    default:      n_st = ST_OUT;
                endcase
            end
            ST_MM_MUL:   n_st = ST_MM_ACC;
            ST_MM_ACC:   n_st = (r_k == 2'd3) ? ((r_e == 4'd15) ? ST_PL_FORM : ST_MM_MUL)
                                              : ST_MM_MUL;
            ST_PL_FORM:  n_st = (r_k == 2'd3) ? ST_PL_SQ : ST_PL_FORM;
            ST_PL_SQ:    n_st = (r_ph && r_k == 2'd2) ? ST_PL_SQRT : ST_PL_SQ;
            ST_PL_SQRT:  if (w_done) n_st = (w_root == '0) ? ST_PL_DSTEP : ST_PL_DIV;
            ST_PL_DIV:   if (w_done) n_st = ST_PL_DSTEP;
            ST_PL_DSTEP: begin
                if (r_len != '0 && r_k != 2'd3) n_st = ST_PL_DIV;
                else if (r_p == 3'd5) n_st = ST_OUT;
                else n_st = ST_PL_FORM;
            end
            ST_T_ADJ:    if (r_ph) n_st = ST_T_MUL;
            ST_T_MUL:    n_st = ST_T_ACC;
            ST_T_ACC:    n_st = (r_k == 2'd2) ? ST_T_CMP : ST_T_MUL;
            ST_T_CMP:    n_st = (r_p == 3'd5) ? ST_OUT : ST_T_MUL;
            ST_OUT:      if (!r_ovld || i_ready) n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else          r_st <= n_st;
    end

    // datapath and stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_ovld   <= 1'b0;
            for (int i = 0; i < 24; i++) r_pl[i] <= '0;
        end else begin
            if (r_st == ST_OUT && (!r_ovld || i_ready)) r_ovld <= 1'b1;
            else if (i_ready) r_ovld <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (i_valid) begin
                    r_in  <= i_data;
                    r_vis <= 1'b0;
                    r_e <= '0; r_k <= '0; r_p <= '0; r_acc <= '0; r_ph <= 1'b0;
                    if (t_func'(i_data.func) == FUNC_LOAD_PROJ)
                        r_proj[i_data.elem_index] <= f_in(i_data.elem_value);
                    if (t_func'(i_data.func) == FUNC_LOAD_MV)
                        r_mv[i_data.elem_index] <= f_in(i_data.elem_value);
                end
                ST_MM_MUL: ;
                ST_MM_ACC: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_clip[r_e] <= f_sat(r_acc + (W+4)'(w_mp));
                        r_acc <= '0;
                        r_e <= r_e + 1'b1;
                    end else begin
                        r_acc <= r_acc + (W+4)'(w_mp);
                    end
                end
                ST_PL_FORM: begin
                    r_pl[{r_p, 2'b00} + 5'(r_k)] <= f_sat((W+4)'(w_form));
                    r_k <= r_k + 1'b1;
                    r_sq <= '0;
                end
                ST_PL_SQ: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_sq <= r_sq + (2*W+2)'(w_msq);
                        r_k  <= (r_k == 2'd2) ? 2'd0 : r_k + 1'b1;
                    end
                end
                ST_PL_SQRT: begin
                    r_ph <= !w_done;
                    if (w_done) begin
                        r_len <= w_root;
                        r_k   <= 2'd0;
                    end
                end
                ST_PL_DIV: begin
                    r_ph <= !w_done;
                    if (w_done) begin
                        r_pl[{r_p, 2'b00} + 5'(r_k)] <= w_quot;
                    end
                end
                ST_PL_DSTEP: begin
                    if (r_len != '0 && r_k != 2'd3) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_k <= '0;
                        r_p <= r_p + 1'b1;
                        if (r_p == 3'd5) r_pvalid <= 1'b1;
                    end
                end
                ST_T_ADJ: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_adj <= f_sat((W+4)'(f_in($signed({1'b0, r_in.radius})))
                                       + (W+4)'(w_mp));
                        r_vis <= 1'b1;
                        r_acc <= '0;
                    end
                end
                ST_T_MUL: ;
                ST_T_ACC: begin
                    r_acc <= r_acc + (W+4)'(w_mp);
                    r_k   <= (r_k == 2'd2) ? 2'd0 : r_k + 1'b1;
                end
                ST_T_CMP: begin
                    if (f_sat(r_acc + (W+4)'(r_pl[{r_p, 2'b11}])) < -r_adj) r_vis <= 1'b0;
                    r_acc <= '0;
                    r_p   <= r_p + 1'b1;
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    // output register holds the last result until taken
    t_out_item r_out;
    always_ff @(posedge i_clk) begin
        if (r_st == ST_OUT && (!r_ovld || i_ready)) begin
            r_out.visible      <= r_vis;
            r_out.planes_valid <= r_pvalid;
        end
    end

    assign o_ready = (r_st == ST_IDLE);
    assign o_valid = r_ovld;
    assign o_data  = r_out;
endmodule
